[rtl/msfd_pkg.sv]
// shared types, codes, threshold bands and counter helpers for the motor stall diagnostic
package msfd_pkg;

   localparam int CNT_W = 16;
   localparam int CMP_W = (CNT_W > 16) ? CNT_W : 16;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic [1:0] OP_TICK        = 2'd0;
   localparam logic [1:0] OP_CLEAR_STALL = 2'd1;
   localparam logic [1:0] OP_CLEAR_FAULT = 2'd2;

   localparam logic [1:0] CLR_ALL    = 2'd0;
   localparam logic [1:0] CLR_FIRST  = 2'd1;
   localparam logic [1:0] CLR_SECOND = 2'd2;
   localparam logic [1:0] CLR_THIRD  = 2'd3;

   localparam logic [2:0] EV_OBSTRUCTION = 3'd0;
   localparam logic [2:0] EV_STALL       = 3'd1;
   localparam logic [2:0] EV_OPEN        = 3'd2;
   localparam logic [2:0] EV_OVERCURRENT = 3'd3;
   localparam logic [2:0] EV_SHORT       = 3'd4;

   localparam logic [2:0] CSR_STALL_ENABLE       = 3'd0;
   localparam logic [2:0] CSR_OPEN_CHECK_ENABLE  = 3'd1;
   localparam logic [2:0] CSR_OC_CHECK_ENABLE    = 3'd2;
   localparam logic [2:0] CSR_MASK_TICKS         = 3'd3;
   localparam logic [2:0] CSR_OBSTRUCTION_LIMIT  = 3'd4;
   localparam logic [2:0] CSR_STALL_LIMIT        = 3'd5;
   localparam logic [2:0] CSR_FAULT_LIMIT        = 3'd6;
   localparam logic [2:0] CSR_OVERCURRENT_MA     = 3'd7;

   typedef struct packed {
      logic [1:0]  op;
      logic [1:0]  clear_type;
      logic [15:0] motor_current;
      logic [15:0] supply_voltage;
      logic [14:0] sensor_delta;
      logic        sensor_stopped;
      logic        drive_enable;
      logic        motor_running;
      logic        short_detected;
      logic        overcurrent_latched;
      logic        calibration_mode;
      logic [15:0] elapsed_time;
   } req_type;

   typedef struct packed {
      logic        stall_temporary;
      logic        stall_permanent;
      logic        fault_open;
      logic        fault_short;
      logic        fault_overcurrent;
      logic        drive_inhibit;
      logic        event_valid;
      logic [2:0]  event_code;
      logic [15:0] event_value;
   } rsp_type;

   typedef struct packed {
      logic        stall_enable;
      logic        open_check_enable;
      logic        overcurrent_check_enable;
      logic [15:0] mask_ticks;
      logic [15:0] obstruction_limit;
      logic [15:0] stall_limit;
      logic [15:0] fault_limit;
      logic [15:0] overcurrent_ma;
   } cfg_type;

   typedef struct packed {
      logic [4:0] motion;
      logic [9:0] obstr;
      logic [9:0] stall;
   } band_type;

   function automatic band_type band_sel(input logic [15:0] volt);
      band_type b;
      if (volt <= 16'd950) begin
         b = '{motion: 5'd10, obstr: 10'd550, stall: 10'd650};
      end else if (volt <= 16'd1050) begin
         b = '{motion: 5'd11, obstr: 10'd600, stall: 10'd700};
      end else if (volt <= 16'd1150) begin
         b = '{motion: 5'd12, obstr: 10'd650, stall: 10'd750};
      end else if (volt <= 16'd1250) begin
         b = '{motion: 5'd14, obstr: 10'd700, stall: 10'd800};
      end else if (volt <= 16'd1450) begin
         b = '{motion: 5'd16, obstr: 10'd800, stall: 10'd900};
      end else begin
         b = '{motion: 5'd17, obstr: 10'd900, stall: 10'd1000};
      end
      return b;
   endfunction

   function automatic logic [CNT_W-1:0] count_step(input logic [CNT_W-1:0] c, input logic up);
      logic [CNT_W-1:0] r;
      if (up) begin
         r = (c != CNT_MAX) ? CNT_W'(c + 1'b1) : c;
      end else begin
         r = (c != '0) ? CNT_W'(c - 1'b1) : '0;
      end
      return r;
   endfunction

   function automatic logic count_ge(input logic [CNT_W-1:0] c, input logic [15:0] limit);
      logic [CMP_W-1:0] a;
      logic [CMP_W-1:0] b;
      a = CMP_W'(c);
      b = CMP_W'(limit);
      return a >= b;
   endfunction

endpackage

[rtl/msfd_csr.sv]
// configuration registers of the motor stall diagnostic
module msfd_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_data,
   output msfd_pkg::cfg_type    cfg
);

   msfd_pkg::cfg_type cfg_ff;
   msfd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            msfd_pkg::CSR_STALL_ENABLE:      cfg_in.stall_enable = csr_data[0];
            msfd_pkg::CSR_OPEN_CHECK_ENABLE: cfg_in.open_check_enable = csr_data[0];
            msfd_pkg::CSR_OC_CHECK_ENABLE:   cfg_in.overcurrent_check_enable = csr_data[0];
            msfd_pkg::CSR_MASK_TICKS:        cfg_in.mask_ticks = csr_data;
            msfd_pkg::CSR_OBSTRUCTION_LIMIT: cfg_in.obstruction_limit = csr_data;
            msfd_pkg::CSR_STALL_LIMIT:       cfg_in.stall_limit = csr_data;
            msfd_pkg::CSR_FAULT_LIMIT:       cfg_in.fault_limit = csr_data;
            msfd_pkg::CSR_OVERCURRENT_MA:    cfg_in.overcurrent_ma = csr_data;
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stall_enable             <= 1'b1;
         cfg_ff.open_check_enable        <= 1'b1;
         cfg_ff.overcurrent_check_enable <= 1'b1;
         cfg_ff.mask_ticks               <= 16'd1000;
         cfg_ff.obstruction_limit        <= 16'd3000;
         cfg_ff.stall_limit              <= 16'd5000;
         cfg_ff.fault_limit              <= 16'd5000;
         cfg_ff.overcurrent_ma           <= 16'd1500;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/msfd_core.sv]
// diagnostic state, counters and flag logic evaluated once per transaction
module msfd_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  msfd_pkg::req_type    req,
   input  msfd_pkg::cfg_type    cfg,
   output msfd_pkg::rsp_type    rsp
);

   logic [15:0]                 mask_timer_ff, mask_timer_in;
   logic [msfd_pkg::CNT_W-1:0]  obstruction_count_ff, obstruction_count_in;
   logic [msfd_pkg::CNT_W-1:0]  stall_count_ff, stall_count_in;
   logic [msfd_pkg::CNT_W-1:0]  open_count_ff, open_count_in;
   logic [msfd_pkg::CNT_W-1:0]  overcurrent_count_ff, overcurrent_count_in;
   logic [1:0]                  stall_flags_ff, stall_flags_in;
   logic [2:0]                  fault_flags_ff, fault_flags_in;

   msfd_pkg::band_type          band;
   logic [15:0]                 ev_value_raw;
   logic                        ev_set;
   logic [2:0]                  ev_code;
   logic                        obs_up;
   logic                        stall_up;

   assign band = msfd_pkg::band_sel(req.supply_voltage);
   assign ev_value_raw = {3'b000, req.motor_current[15:3]} | {req.elapsed_time[15:8], 8'h00};
   assign obs_up = (req.motor_current >= {6'b0, band.obstr})
                   && (req.sensor_delta < {10'b0, band.motion})
                   && (req.sensor_delta > 15'd3);
   assign stall_up = (req.motor_current >= {6'b0, band.stall}) && req.sensor_stopped;

   always_comb begin
      mask_timer_in        = mask_timer_ff;
      obstruction_count_in = obstruction_count_ff;
      stall_count_in       = stall_count_ff;
      open_count_in        = open_count_ff;
      overcurrent_count_in = overcurrent_count_ff;
      stall_flags_in       = stall_flags_ff;
      fault_flags_in       = fault_flags_ff;
      ev_set               = 1'b0;
      ev_code              = msfd_pkg::EV_OBSTRUCTION;
      case (req.op)
         msfd_pkg::OP_CLEAR_STALL: begin
            case (req.clear_type)
               msfd_pkg::CLR_ALL:   stall_flags_in = 2'b00;
               msfd_pkg::CLR_FIRST: stall_flags_in[0] = 1'b0;
               default:             stall_flags_in[1] = 1'b0;
            endcase
         end
         msfd_pkg::OP_CLEAR_FAULT: begin
            case (req.clear_type)
               msfd_pkg::CLR_ALL:    fault_flags_in = 3'b000;
               msfd_pkg::CLR_FIRST:  fault_flags_in[0] = 1'b0;
               msfd_pkg::CLR_SECOND: fault_flags_in[1] = 1'b0;
               default:              fault_flags_in[2] = 1'b0;
            endcase
         end
         msfd_pkg::OP_TICK: begin
            if (req.drive_enable) begin
               if (mask_timer_ff != 16'hffff) begin
                  mask_timer_in = mask_timer_ff + 16'd1;
               end
               if (mask_timer_in >= cfg.mask_ticks) begin
                  obstruction_count_in = msfd_pkg::count_step(obstruction_count_ff, obs_up);
                  if (msfd_pkg::count_ge(obstruction_count_in, cfg.obstruction_limit)
                      && cfg.stall_enable && !req.calibration_mode) begin
                     stall_flags_in[0] = 1'b1;
                     ev_set = 1'b1;
                     ev_code = msfd_pkg::EV_OBSTRUCTION;
                  end
                  stall_count_in = msfd_pkg::count_step(stall_count_ff, stall_up);
                  if (msfd_pkg::count_ge(stall_count_in, cfg.stall_limit)
                      && cfg.stall_enable) begin
                     stall_flags_in[1] = 1'b1;
                     ev_set = 1'b1;
                     ev_code = msfd_pkg::EV_STALL;
                  end
               end else begin
                  obstruction_count_in = '0;
                  stall_count_in = '0;
               end
            end else begin
               mask_timer_in = 16'd0;
            end

            if (req.motor_running) begin
               open_count_in = msfd_pkg::count_step(open_count_ff,
                  (req.motor_current <= 16'd5) && req.sensor_stopped);
               if (msfd_pkg::count_ge(open_count_in, cfg.fault_limit)
                   && cfg.open_check_enable) begin
                  fault_flags_in[0] = 1'b1;
                  ev_set = 1'b1;
                  ev_code = msfd_pkg::EV_OPEN;
               end
            end else begin
               open_count_in = '0;
            end

            if (req.drive_enable && (stall_flags_in == 2'b00)) begin
               overcurrent_count_in = msfd_pkg::count_step(overcurrent_count_ff,
                  req.motor_current >= cfg.overcurrent_ma);
               if (msfd_pkg::count_ge(overcurrent_count_in, cfg.fault_limit)
                   && cfg.overcurrent_check_enable) begin
                  fault_flags_in[2] = 1'b1;
                  ev_set = 1'b1;
                  ev_code = msfd_pkg::EV_OVERCURRENT;
               end
            end else begin
               overcurrent_count_in = '0;
            end

            if (req.short_detected) begin
               fault_flags_in[1] = 1'b1;
               ev_set = 1'b1;
               ev_code = msfd_pkg::EV_SHORT;
            end else if (req.overcurrent_latched) begin
               fault_flags_in[2] = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_timer_ff        <= '0;
         obstruction_count_ff <= '0;
         stall_count_ff       <= '0;
         open_count_ff        <= '0;
         overcurrent_count_ff <= '0;
         stall_flags_ff       <= '0;
         fault_flags_ff       <= '0;
      end else if (fire) begin
         mask_timer_ff        <= mask_timer_in;
         obstruction_count_ff <= obstruction_count_in;
         stall_count_ff       <= stall_count_in;
         open_count_ff        <= open_count_in;
         overcurrent_count_ff <= overcurrent_count_in;
         stall_flags_ff       <= stall_flags_in;
         fault_flags_ff       <= fault_flags_in;
      end
   end

   always_comb begin
      rsp.stall_temporary   = stall_flags_in[0];
      rsp.stall_permanent   = stall_flags_in[1];
      rsp.fault_open        = fault_flags_in[0];
      rsp.fault_short       = fault_flags_in[1];
      rsp.fault_overcurrent = fault_flags_in[2];
      rsp.drive_inhibit     = (|stall_flags_in) | (|fault_flags_in);
      rsp.event_valid       = ev_set;
      rsp.event_code        = ev_set ? ev_code : msfd_pkg::EV_OBSTRUCTION;
      rsp.event_value       = ev_set ? ev_value_raw : 16'd0;
   end

endmodule

[rtl/motor_stall_fault_diagnostic.sv]
// top level of the motor stall and fault diagnostic
//
//   port group   direction   handshake            payload
//   req_         in          req_valid/req_stall  req_data (msfd_pkg::req_type)
//   rsp_         out         rsp_valid/rsp_stall  rsp_data (msfd_pkg::rsp_type)
//   csr_         in          csr_write_enable     csr_index, csr_data
//
// one transaction per clock sustained while rsp_stall is low; each passes the input register, then the result register
// the flag and counter update sits between the input register and the result register
// synchronous reset restores register defaults and clears counters and flags
// a held result stalls the input register, which then stalls req_
module motor_stall_fault_diagnostic (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  msfd_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output msfd_pkg::rsp_type    rsp_data,
   input  logic                 csr_write_enable,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_data
);

   logic                 in_valid_ff, in_valid_in;
   msfd_pkg::req_type    in_data_ff;
   logic                 out_valid_ff, out_valid_in;
   msfd_pkg::rsp_type    out_data_ff;
   msfd_pkg::rsp_type    core_rsp;
   msfd_pkg::cfg_type    cfg;
   logic                 fire;
   logic                 req_take;

   msfd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   msfd_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (in_data_ff),
      .cfg   (cfg),
      .rsp   (core_rsp)
   );

   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= core_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
